### sv/zoh_resampler_soft_limiter_assert.svh
// Assertion macros shared by the checker of the resampler and limiter.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ZOH_RESAMPLER_SOFT_LIMITER_ASSERT_SVH
`define ZOH_RESAMPLER_SOFT_LIMITER_ASSERT_SVH

// Implication checked while reset is released.
`define ZOHSL_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define ZOHSL_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication checked while reset is released.
`define ZOHSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/zohsl_pkg.sv
// ----------------------------------------------------------------------------
// zohsl_pkg
// Shared constants for the zero-order-hold resampler with soft limiter.
// ----------------------------------------------------------------------------
package zohsl_pkg;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_OUT_FRAMES   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IN_FRAMES    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ATTACK_COEFF = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RELEASE_COEF = 3'd5;

  // Register reset values
  localparam logic [15:0] PHASE_STEP_RST = 16'd60211;
  localparam logic [10:0] OUT_FRAMES_RST = 11'd256;
  localparam logic [10:0] IN_FRAMES_RST  = 11'd236;
  localparam logic [14:0] THRESHOLD_RST  = 15'd27852;
  localparam logic [23:0] ATTACK_RST     = 24'd16431300;
  localparam logic [23:0] RELEASE_RST    = 24'd16773721;

  // Datapath
  localparam int          BLOCK_MAX_DEF = 1024;
  localparam int          ACC_W         = 26;
  localparam int          MAC_STEPS     = 25;
  localparam int          DIV_STEPS     = 23;
  localparam int          MAC_W         = 50;
  localparam logic [23:0] GAIN_ONE      = 24'h800000;
  localparam logic [24:0] Q24_ONE       = 25'h1000000;

endpackage

### sv/zohsl_mac.sv
// ----------------------------------------------------------------------------
// zohsl_mac
// Bit-serial multiply-accumulate: a*ca + b*cb, one coefficient bit per cycle.
// ----------------------------------------------------------------------------
module zohsl_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [23:0]                   mul_a,
  input  logic [23:0]                   mul_b,
  input  logic [24:0]                   coef_a,
  input  logic [24:0]                   coef_b,
  output logic                          done,
  output logic [zohsl_pkg::MAC_W-1:0]   result
);

  logic [23:0]                 a_r, b_r;
  logic [24:0]                 ca_r, cb_r;
  logic [zohsl_pkg::MAC_W-1:0] acc_r, acc_nxt;
  logic [4:0]                  cnt_r;
  logic                        run_r, done_r;

  // One shifted partial sum per cycle, coefficient MSB first
  always_comb begin
    acc_nxt = {acc_r[zohsl_pkg::MAC_W-2:0], 1'b0}
            + (ca_r[24] ? zohsl_pkg::MAC_W'(a_r) : '0)
            + (cb_r[24] ? zohsl_pkg::MAC_W'(b_r) : '0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(zohsl_pkg::MAC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mul_a;
      b_r   <= mul_b;
      ca_r  <= coef_a;
      cb_r  <= coef_b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      ca_r  <= {ca_r[23:0], 1'b0};
      cb_r  <= {cb_r[23:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### sv/zohsl_div.sv
// ----------------------------------------------------------------------------
// zohsl_div
// Restoring divider, one quotient bit per cycle, for the limiter target gain.
// ----------------------------------------------------------------------------
module zohsl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] rem_init,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [22:0] quot
);

  logic [23:0] rem_r, den_r;
  logic [22:0] q_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r;
  logic [24:0] rem_sh, diff;
  logic        ge;

  // Trial subtraction of the shifted remainder
  always_comb begin
    rem_sh = {rem_r, 1'b0};
    diff   = rem_sh - {1'b0, den_r};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(zohsl_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      den_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[23:0] : rem_sh[23:0];
      q_r   <= {q_r[21:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### sv/zoh_resampler_soft_limiter.sv
// ----------------------------------------------------------------------------
// zoh_resampler_soft_limiter
// Zero-order-hold resampler followed by a stereo-linked soft limiter.
// ----------------------------------------------------------------------------
// Input frames arrive on in_* (left sample in the low half of tdata) and each
// gives zero, one or two limited output frames on out_* (tuser bit 0 marks
// the last output of the input frame, bit 1 the last output of a block).
// Registers are written through cfg_* while the block is idle; the user
// must keep to this, the block itself does not enforce it.
// One input frame is taken at a time: in_tready is high only when the block
// is idle. Each output frame passes through the serial arithmetic: an
// envelope smoothing, a divide, a gain smoothing and a scaling pass, run one
// after the other. An instant envelope attack skips the smoothing and a level
// not above the threshold skips the divide. Reset restores the register
// defaults, clears the counters and envelope and sets the gain to one. A
// finished frame waits in the output register; while the receiver stalls the
// block holds the next frame until the register is free, and accepts no new
// input.
// ----------------------------------------------------------------------------
module zoh_resampler_soft_limiter #(
  parameter int BLOCK_MAX = zohsl_pkg::BLOCK_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // left_in[15:0], right_in[31:16]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // left_out[15:0], right_out[31:16]
  output logic [1:0]                    out_tuser,  // last_of_run[0], block_end[1]
  input  logic                          cfg_wr_en,
  input  logic [zohsl_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [zohsl_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int IW = $clog2(BLOCK_MAX);
  localparam int NW = IW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_ENV  = 4'd2;
  localparam logic [3:0] S_ENVW = 4'd3;
  localparam logic [3:0] S_TGT  = 4'd4;
  localparam logic [3:0] S_DIVW = 4'd5;
  localparam logic [3:0] S_GSM  = 4'd6;
  localparam logic [3:0] S_GSMW = 4'd7;
  localparam logic [3:0] S_SCL  = 4'd8;
  localparam logic [3:0] S_SCLW = 4'd9;
  localparam logic [3:0] S_NEXT = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  // Configuration registers
  logic [15:0] phase_step_r;
  logic [10:0] out_frames_r, in_frames_r;
  logic [14:0] thr_r;
  logic [23:0] att_r, rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= zohsl_pkg::PHASE_STEP_RST;
      out_frames_r <= zohsl_pkg::OUT_FRAMES_RST;
      in_frames_r  <= zohsl_pkg::IN_FRAMES_RST;
      thr_r        <= zohsl_pkg::THRESHOLD_RST;
      att_r        <= zohsl_pkg::ATTACK_RST;
      rel_r        <= zohsl_pkg::RELEASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        zohsl_pkg::REG_PHASE_STEP:   phase_step_r <= cfg_wdata[15:0];
        zohsl_pkg::REG_OUT_FRAMES:   out_frames_r <= cfg_wdata[10:0];
        zohsl_pkg::REG_IN_FRAMES:    in_frames_r  <= cfg_wdata[10:0];
        zohsl_pkg::REG_THRESHOLD:    thr_r        <= cfg_wdata[14:0];
        zohsl_pkg::REG_ATTACK_COEFF: att_r        <= cfg_wdata[23:0];
        zohsl_pkg::REG_RELEASE_COEF: rel_r        <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // State
  logic [3:0]                  state_r;
  logic [zohsl_pkg::ACC_W-1:0] acc_r;
  logic [IW-1:0]               idx_r;
  logic [NW-1:0]               oc_r, nout_r;
  logic [1:0]                  n_r;
  logic                        last_in_r, blk_end_r, more_r;
  logic [23:0]                 env_r, gain_r, target_r;
  logic [15:0]                 left_r, right_r, res_l_r, res_r_r;
  logic                        out_valid_r;
  logic [31:0]                 out_data_r;
  logic [1:0]                  out_user_r;

  // Block sizes, zero counted as one and clamped to the maximum
  logic [NW-1:0] nin_eff, nout_eff;
  logic          last_in_nxt;

  always_comb begin
    if (in_frames_r == 11'd0) nin_eff = NW'(1);
    else if (32'(in_frames_r) > BLOCK_MAX) nin_eff = NW'(BLOCK_MAX);
    else nin_eff = NW'(in_frames_r);
    if (out_frames_r == 11'd0) nout_eff = NW'(1);
    else if (32'(out_frames_r) > BLOCK_MAX) nout_eff = NW'(BLOCK_MAX);
    else nout_eff = NW'(out_frames_r);
    last_in_nxt = (32'(idx_r) + 32'd1) >= 32'(nin_eff);
  end

  // Whether the current input emits another output
  logic cond;
  assign cond = (n_r != 2'd2) && (32'(oc_r) < 32'(nout_r))
             && (last_in_r || (32'(acc_r[zohsl_pkg::ACC_W-1:16]) <= 32'(idx_r)));

  // Channel magnitudes and the linked peak in Q16.8
  logic [15:0] mag_l, mag_r;
  logic [23:0] peak;
  logic [23:0] thr_q8;

  always_comb begin
    mag_l  = left_r[15] ? 16'(-left_r) : left_r;
    mag_r  = right_r[15] ? 16'(-right_r) : right_r;
    peak   = (mag_l > mag_r) ? {mag_l, 8'd0} : {mag_r, 8'd0};
    thr_q8 = {1'b0, thr_r, 8'd0};
  end

  // Serial arithmetic units
  logic                        mac0_start, mac1_start, mac0_done, mac1_done;
  logic [23:0]                 mac0_a, mac0_b;
  logic [24:0]                 mac0_ca, mac0_cb, gain_ext;
  logic [23:0]                 gcoef;
  logic [zohsl_pkg::MAC_W-1:0] mac0_res, mac1_res;
  logic                        div_start, div_done;
  logic [22:0]                 div_q;
  logic                        scl_done;

  always_comb begin
    gcoef    = (target_r < gain_r) ? att_r : rel_r;
    gain_ext = {1'b0, gain_r};
    mac0_a   = env_r;
    mac0_b   = peak;
    mac0_ca  = {1'b0, rel_r};
    mac0_cb  = zohsl_pkg::Q24_ONE - {1'b0, rel_r};
    if (state_r == S_GSM) begin
      mac0_a  = gain_r;
      mac0_b  = target_r;
      mac0_ca = {1'b0, gcoef};
      mac0_cb = zohsl_pkg::Q24_ONE - {1'b0, gcoef};
    end else if (state_r == S_SCL) begin
      mac0_a  = {8'd0, mag_l};
      mac0_b  = '0;
      mac0_ca = gain_ext;
      mac0_cb = '0;
    end
    mac0_start = ((state_r == S_ENV) && !(peak > env_r))
              || (state_r == S_GSM) || (state_r == S_SCL);
    mac1_start = (state_r == S_SCL);
    div_start  = (state_r == S_TGT) && (env_r > thr_q8);
    scl_done   = mac0_done && mac1_done;
  end

  zohsl_mac u_mac0 (
    .clk(clk), .rst_n(rst_n), .start(mac0_start),
    .mul_a(mac0_a), .mul_b(mac0_b), .coef_a(mac0_ca), .coef_b(mac0_cb),
    .done(mac0_done), .result(mac0_res)
  );

  zohsl_mac u_mac1 (
    .clk(clk), .rst_n(rst_n), .start(mac1_start),
    .mul_a({8'd0, mag_r}), .mul_b(24'd0), .coef_a(gain_ext), .coef_b(25'd0),
    .done(mac1_done), .result(mac1_res)
  );

  zohsl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .rem_init(thr_q8), .divisor(env_r),
    .done(div_done), .quot(div_q)
  );

  // Restore the sign of a scaled magnitude and saturate to 16 bits
  function automatic logic [15:0] sat_scale(input logic neg, input logic [16:0] m);
    logic [15:0] v;
    if (neg) v = (m > 17'd32768) ? 16'h8000 : 16'(-m);
    else     v = (m > 17'd32767) ? 16'h7FFF : m[15:0];
    return v;
  endfunction

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // Sequencer and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      idx_r       <= '0;
      oc_r        <= '0;
      n_r         <= '0;
      env_r       <= '0;
      gain_r      <= zohsl_pkg::GAIN_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          n_r     <= '0;
          state_r <= S_CHK;
        end
        S_CHK:  state_r <= cond ? S_ENV : S_FIN;
        S_ENV: begin
          if (peak > env_r) begin
            env_r   <= peak;
            state_r <= S_TGT;
          end else begin
            state_r <= S_ENVW;
          end
        end
        S_ENVW: if (mac0_done) begin
          env_r   <= mac0_res[47:24];
          state_r <= S_TGT;
        end
        S_TGT:  state_r <= div_start ? S_DIVW : S_GSM;
        S_DIVW: if (div_done) state_r <= S_GSM;
        S_GSM:  state_r <= S_GSMW;
        S_GSMW: if (mac0_done) begin
          gain_r  <= mac0_res[47:24];
          state_r <= S_SCL;
        end
        S_SCL:  state_r <= S_SCLW;
        S_SCLW: if (scl_done) begin
          oc_r    <= oc_r + NW'(1);
          acc_r   <= acc_r + zohsl_pkg::ACC_W'(phase_step_r);
          n_r     <= n_r + 2'd1;
          state_r <= S_NEXT;
        end
        S_NEXT: state_r <= S_EMIT;
        S_EMIT: if (out_free) begin
          out_valid_r <= 1'b1;
          state_r     <= more_r ? S_ENV : S_FIN;
        end
        S_FIN: begin
          if (last_in_r) begin
            acc_r <= '0;
            idx_r <= '0;
            oc_r  <= '0;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      left_r    <= in_tdata[15:0];
      right_r   <= in_tdata[31:16];
      nout_r    <= nout_eff;
      last_in_r <= last_in_nxt;
    end
    if (state_r == S_TGT) target_r <= zohsl_pkg::GAIN_ONE;
    if (state_r == S_DIVW && div_done) target_r <= {1'b0, div_q};
    if (state_r == S_SCLW && scl_done) begin
      res_l_r   <= sat_scale(left_r[15], mac0_res[39:23]);
      res_r_r   <= sat_scale(right_r[15], mac1_res[39:23]);
      blk_end_r <= (oc_r + NW'(1)) == nout_r;
    end
    if (state_r == S_NEXT) more_r <= cond;
    if (state_r == S_EMIT && out_free) begin
      out_data_r <= {res_r_r, res_l_r};
      out_user_r <= {blk_end_r, !more_r};
    end
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### sv/zohsl_checker.sv
// ----------------------------------------------------------------------------
// zohsl_checker
// Port-level checks for the resampler and limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "zoh_resampler_soft_limiter_assert.svh"

module zohsl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [1:0]                    out_tuser
);

  // A stalled output transfer stays offered.
  `ZOHSL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "output dropped while stalled")

  // The block works on one input frame at a time.
  `ZOHSL_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // The end of a block is always the last output of its input frame.
  `ZOHSL_ASSERT(a_blk_last, out_tvalid && out_tuser[1], out_tuser[0], "block end not last of run")

  // Reset empties the output register.
  `ZOHSL_ASSERT_NEXT_RST(a_rst_empty, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind zoh_resampler_soft_limiter zohsl_checker u_zohsl_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the zero-order-hold resampler with soft limiter.
// Stereo frames are streamed in under several register settings and idling
// patterns. A scoreboard predicts the held and limited output frames of every
// accepted input and compares each output transfer with the oldest one.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 260;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last_of_run;
    logic        block_end;
  } frame_t;

  // Scoreboard: predicts the resampler and limiter and checks results.
  class hold_limiter_board;
    int unsigned step, out_blk, in_blk, thresh, att, rel;
    int unsigned accum, in_idx, out_cnt, env, gain;
    frame_t      pending[$];
    int          errors;

    function new();
      step    = zohsl_pkg::PHASE_STEP_RST;
      out_blk = zohsl_pkg::OUT_FRAMES_RST;
      in_blk  = zohsl_pkg::IN_FRAMES_RST;
      thresh  = zohsl_pkg::THRESHOLD_RST;
      att     = zohsl_pkg::ATTACK_RST;
      rel     = zohsl_pkg::RELEASE_RST;
      accum   = 0;
      in_idx  = 0;
      out_cnt = 0;
      env     = 0;
      gain    = zohsl_pkg::GAIN_ONE;
      errors  = 0;
    endfunction

    function void set_reg(logic [zohsl_pkg::CFG_AW-1:0] idx, int unsigned val);
      case (idx)
        zohsl_pkg::REG_PHASE_STEP:   step    = val & 32'hFFFF;
        zohsl_pkg::REG_OUT_FRAMES:   out_blk = val & 32'h7FF;
        zohsl_pkg::REG_IN_FRAMES:    in_blk  = val & 32'h7FF;
        zohsl_pkg::REG_THRESHOLD:    thresh  = val & 32'h7FFF;
        zohsl_pkg::REG_ATTACK_COEFF: att     = val & 32'hFFFFFF;
        zohsl_pkg::REG_RELEASE_COEF: rel     = val & 32'hFFFFFF;
        default: ;
      endcase
    endfunction

    function int unsigned block_size(int unsigned v);
      if (v == 0) return 1;
      if (v > zohsl_pkg::BLOCK_MAX_DEF) return zohsl_pkg::BLOCK_MAX_DEF;
      return v;
    endfunction

    function int unsigned blend(int unsigned prev, int unsigned nw, int unsigned c);
      longint unsigned acc;
      acc = longint'(prev) * c + longint'(nw) * ((64'd1 << 24) - c);
      return int'(acc >> 24);
    endfunction

    // Truncate toward zero, then saturate to 16 bits.
    function logic [15:0] apply_gain(int s, int unsigned g);
      longint unsigned m;
      longint          v;
      m = (longint'(s < 0 ? -s : s) * g) >> 23;
      v = (s < 0) ? -longint'(m) : longint'(m);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    // Update envelope and gain for one output frame.
    function void limit_frame(int l, int r, output frame_t f);
      int unsigned peak, target;
      int unsigned al, ar;
      al   = (l < 0) ? -l : l;
      ar   = (r < 0) ? -r : r;
      peak = ((al > ar) ? al : ar) << 8;
      if (peak > env) env = peak;
      else env = blend(env, peak, rel);
      if (env > (thresh << 8)) target = int'((longint'(thresh) << 31) / env);
      else target = zohsl_pkg::GAIN_ONE;
      if (target < gain) gain = blend(gain, target, att);
      else gain = blend(gain, target, rel);
      f.left        = apply_gain(l, gain);
      f.right       = apply_gain(r, gain);
      f.last_of_run = 1'b0;
      f.block_end   = 1'b0;
    endfunction

    // Note an accepted input frame and queue the outputs it causes.
    function void note_input(logic signed [15:0] l, logic signed [15:0] r);
      int unsigned nin, nout;
      bit          last_in;
      int          n;
      frame_t      f;
      nin     = block_size(in_blk);
      nout    = block_size(out_blk);
      last_in = (in_idx + 1 >= nin);
      n       = 0;
      while (n < 2 && out_cnt < nout && (last_in || (accum >> 16) <= in_idx)) begin
        limit_frame(l, r, f);
        out_cnt++;
        accum       = (accum + step) & 32'h3FFFFFF;
        f.block_end = (out_cnt == nout);
        pending.push_back(f);
        n++;
      end
      if (n > 0) pending[$].last_of_run = 1'b1;
      if (last_in) begin
        accum   = 0;
        in_idx  = 0;
        out_cnt = 0;
      end else begin
        in_idx++;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [31:0] data, logic [1:0] user);
      frame_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output %h/%b", data, user));
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.left)
        report($sformatf("left_out %h, want %h", data[15:0], e.left));
      if (data[31:16] !== e.right)
        report($sformatf("right_out %h, want %h", data[31:16], e.right));
      if (user[0] !== e.last_of_run)
        report($sformatf("last_of_run %b, want %b", user[0], e.last_of_run));
      if (user[1] !== e.block_end)
        report($sformatf("block_end %b, want %b", user[1], e.block_end));
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [31:0]                 in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [31:0]                 out_tdata;
  logic [1:0]                  out_tuser;
  logic                        cfg_wr_en = 1'b0;
  logic [zohsl_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [zohsl_pkg::CFG_DW-1:0] cfg_wdata = '0;

  hold_limiter_board board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  zoh_resampler_soft_limiter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, output checks and the watchdog.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Stop offering input, then wait until every expected frame has come and
  // the block has settled.
  task wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable afterwards.
  task write_reg(logic [zohsl_pkg::CFG_AW-1:0] idx, int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[zohsl_pkg::CFG_DW-1:0];
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task configure(int unsigned stp, int unsigned ob, int unsigned ib,
                 int unsigned thr, int unsigned a, int unsigned r);
    wait_drained();
    write_reg(zohsl_pkg::REG_PHASE_STEP, stp);
    write_reg(zohsl_pkg::REG_OUT_FRAMES, ob);
    write_reg(zohsl_pkg::REG_IN_FRAMES, ib);
    write_reg(zohsl_pkg::REG_THRESHOLD, thr);
    write_reg(zohsl_pkg::REG_ATTACK_COEFF, a);
    write_reg(zohsl_pkg::REG_RELEASE_COEF, r);
    cfg_wr_en <= 1'b0;
  endtask

  // One input transfer, after an optional random idle gap.
  task send_frame(logic [15:0] l, logic [15:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(l, r);
  endtask

  function logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(300))
                                   : 16'h8000 + 16'($urandom_range(300));
      1: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task send_random(int count);
    for (int i = 0; i < count; i++) send_frame(pick_sample(), pick_sample());
  endtask

  int unsigned steps[8]  = '{60211, 32768, 65535, 45000, 50000, 32768, 65535, 60000};
  int unsigned outs[8]   = '{16, 1, 9, 0, 5, 40, 2047, 12};
  int unsigned ins[8]    = '{15, 1, 9, 1, 7, 20, 3, 11};
  int unsigned thrs[8]   = '{27852, 0, 32767, 8000, 16000, 1000, 20000, 30000};
  int unsigned atts[8]   = '{16431300, 0, 16777215, 12000000, 8000000, 16777215, 0, 16000000};
  int unsigned rels[8]   = '{16773721, 16777215, 0, 14000000, 16777215, 9000000, 0, 16700000};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sample extremes under the reset settings.
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'hFFFF, 16'h0001);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hAAAA, 16'h5555);
    // Zero block sizes count as one.
    configure(60211, 0, 0, 0, 0, 16777215);
    send_frame(16'h8000, 16'h1234);
    send_frame(16'h0100, 16'hFF00);
    // Oversized blocks clamp, then a smaller limit ends the block mid-way.
    configure(65535, 2047, 2047, 32767, 16777215, 0);
    send_frame(16'h7FFF, 16'h0000);
    send_frame(16'h1000, 16'h8001);
    send_frame(16'h4000, 16'hC000);
    configure(65535, 1, 2, 32767, 16777215, 0);
    send_frame(16'h2222, 16'h3333);
    send_frame(16'h4444, 16'h5555);
    // A tiny phase step leaves outputs over for later inputs.
    configure(1, 8, 5, 100, 8000000, 8000000);
    for (int i = 0; i < 6; i++) send_frame(16'h7000 + 16'(i), 16'h9000 - 16'(i));
    // Surplus inputs after the block quota.
    configure(40000, 2, 6, 27852, 16431300, 16773721);
    for (int i = 0; i < 4; i++) send_frame(16'h8000, 16'h7FFF);

    // Random phases under varied settings and idling.
    for (int p = 0; p < 8; p++) begin
      configure(steps[p], outs[p], ins[p], thrs[p], atts[p], rels[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      send_random(70);
      // Hold off until the block has emptied once.
      if (p == 3) wait_drained();
      send_random(70);
    end

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/zohsl_pkg.sv
sv/zohsl_mac.sv
sv/zohsl_div.sv
sv/zoh_resampler_soft_limiter.sv
sv/zohsl_checker.sv
tb/testbench.sv
